### rtl/esc_pkg.sv
// Shared types, constants and command codes for the escape-time iterator.
`timescale 1ns / 1ps
`default_nettype none
package esc_pkg;

  // Default arithmetic configuration.
  localparam int FRAC_BITS_DEF = 49;
  localparam int WORD_BITS_DEF = 64;

  // Fixed field widths.
  localparam int IN_BITS   = 54;
  localparam int CNT_BITS  = 16;
  localparam int IN_TDATA  = 112;
  localparam logic [CNT_BITS-1:0] MAX_ITER_RESET = 16'd256;

  // Multiplier geometry: operands are widened to MUL_BITS and split in halves.
  localparam int MUL_BITS  = 64;
  localparam int HALF_BITS = 32;
  localparam int PROD_BITS = 128;

  // Which product the shared multiplier is working on.
  localparam logic [1:0] OP_XY = 2'd0;
  localparam logic [1:0] OP_XX = 2'd1;
  localparam logic [1:0] OP_YY = 2'd2;

  // Steps of one multiplication.
  localparam logic [2:0] STEP_FIRST_ADD = 3'd1;
  localparam logic [2:0] STEP_LAST_PP   = 3'd3;
  localparam logic [2:0] STEP_LAST_ADD  = 3'd4;
  localparam logic [2:0] STEP_CORR      = 3'd5;
  localparam logic [2:0] STEP_WB        = 3'd6;

  typedef struct packed {
    logic       load;
    logic       mul_en;
    logic [1:0] op;
    logic [2:0] step;
    logic       out_load;
  } cmd_t;

  typedef struct packed {
    logic stop;
  } status_t;

endpackage
`default_nettype wire

### rtl/esc_datapath.sv
// Datapath: point registers, iterated 64x64 multiplier, update logic and count.
`timescale 1ns / 1ps
`default_nettype none
module esc_datapath #(
  parameter int FRAC_BITS = esc_pkg::FRAC_BITS_DEF,
  parameter int WORD_BITS = esc_pkg::WORD_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [esc_pkg::CNT_BITS-1:0]   cfg_data,
  input  wire logic [esc_pkg::IN_BITS-1:0]    c_real,
  input  wire logic [esc_pkg::IN_BITS-1:0]    c_imag,
  input  wire esc_pkg::cmd_t                  cmd,
  output esc_pkg::status_t                    status,
  output logic [esc_pkg::CNT_BITS-1:0]        escape_count
);

  localparam int MB = esc_pkg::MUL_BITS;
  localparam int HB = esc_pkg::HALF_BITS;
  localparam int PB = esc_pkg::PROD_BITS;
  localparam int CB = esc_pkg::CNT_BITS;
  localparam logic [MB-1:0] FOUR_FULL = 64'd4 << FRAC_BITS;
  localparam logic [WORD_BITS-1:0] FOUR = FOUR_FULL[WORD_BITS-1:0];

  logic [CB-1:0]        iter_max;
  logic [CB-1:0]        count;
  logic [WORD_BITS-1:0] cx, cy, zx, zy, x2, y2;
  logic [2*HB-1:0]      pp;
  logic [1:0]           pp_sh;
  logic [PB-1:0]        acc;

  logic signed [WORD_BITS-1:0] op_a, op_b;
  logic signed [MB-1:0]        a64, b64;
  logic signed [MB-1:0]        re_ext, im_ext;
  logic [HB-1:0]               a_part, b_part;
  logic [PB-1:0]               pp_shifted;
  logic [MB-1:0]               corr;
  logic signed [PB-1:0]        acc_s, acc_shr;
  logic [WORD_BITS-1:0]        mul_res;
  logic [WORD_BITS-1:0]        mag;
  logic [CB-1:0]               limit;

  // Operand selection for the shared multiplier.
  always_comb begin
    unique case (cmd.op)
      esc_pkg::OP_XY: begin
        op_a = zx;
        op_b = zy;
      end
      esc_pkg::OP_XX: begin
        op_a = zx;
        op_b = zx;
      end
      esc_pkg::OP_YY: begin
        op_a = zy;
        op_b = zy;
      end
      default: begin
        op_a = zx;
        op_b = zy;
      end
    endcase
  end

  assign a64    = MB'(op_a);
  assign b64    = MB'(op_b);
  assign re_ext = MB'($signed(c_real));
  assign im_ext = MB'($signed(c_imag));

  // Step bit 0 picks the upper half of a, bit 1 the upper half of b.
  assign a_part = cmd.step[0] ? a64[MB-1:HB] : a64[HB-1:0];
  assign b_part = cmd.step[1] ? b64[MB-1:HB] : b64[HB-1:0];
  assign pp_shifted = PB'(pp) << (HB * pp_sh);

  // Unsigned product of the widened words becomes signed by subtracting
  // the other operand from the upper half for each negative operand.
  assign corr = (a64[MB-1] ? b64 : '0) + (b64[MB-1] ? a64 : '0);

  assign acc_s   = acc;
  assign acc_shr = acc_s >>> FRAC_BITS;
  assign mul_res = acc_shr[WORD_BITS-1:0];

  assign mag   = x2 + y2;
  assign limit = iter_max - 16'd1;
  assign status.stop = ($signed(mag) > $signed(FOUR)) || (count >= limit);

  always_ff @(posedge clk) begin
    if (rst) begin
      iter_max <= esc_pkg::MAX_ITER_RESET;
    end else if (cfg_we) begin
      iter_max <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cx    <= re_ext[WORD_BITS-1:0];
      cy    <= im_ext[WORD_BITS-1:0];
      zx    <= '0;
      zy    <= '0;
      x2    <= '0;
      y2    <= '0;
      count <= '0;
    end else if (cmd.mul_en) begin
      if (cmd.step <= esc_pkg::STEP_LAST_PP) begin
        pp    <= a_part * b_part;
        pp_sh <= {1'b0, cmd.step[0]} + {1'b0, cmd.step[1]};
      end
      if (cmd.step == esc_pkg::STEP_FIRST_ADD) begin
        acc <= pp_shifted;
      end else if (cmd.step > esc_pkg::STEP_FIRST_ADD &&
                   cmd.step <= esc_pkg::STEP_LAST_ADD) begin
        acc <= acc + pp_shifted;
      end else if (cmd.step == esc_pkg::STEP_CORR) begin
        acc[PB-1:MB] <= acc[PB-1:MB] - corr;
      end
      if (cmd.step == esc_pkg::STEP_WB) begin
        unique case (cmd.op)
          esc_pkg::OP_XY: begin
            zy <= (mul_res << 1) + cy;
            zx <= x2 - y2 + cx;
          end
          esc_pkg::OP_XX: begin
            x2 <= mul_res;
          end
          esc_pkg::OP_YY: begin
            y2    <= mul_res;
            count <= count + 16'd1;
          end
          default: begin
            x2 <= x2;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      escape_count <= count;
    end
  end

endmodule
`default_nettype wire

### rtl/esc_ctrl.sv
// Controller: sequences load, escape test, the three products of a round and output.
`timescale 1ns / 1ps
`default_nettype none
module esc_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  output logic                  m_tvalid,
  input  wire logic             m_tready,
  input  wire esc_pkg::status_t status,
  output esc_pkg::cmd_t         cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_TEST = 2'd1;
  localparam logic [1:0] S_MUL  = 2'd2;
  localparam logic [1:0] S_DONE = 2'd3;

  logic [1:0] state, state_next;
  logic [1:0] op, op_next;
  logic [2:0] step, step_next;
  logic       out_free;

  assign s_tready = (state == S_IDLE);
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next   = state;
    op_next      = op;
    step_next    = step;
    cmd.load     = 1'b0;
    cmd.mul_en   = 1'b0;
    cmd.op       = op;
    cmd.step     = step;
    cmd.out_load = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          cmd.load   = 1'b1;
          state_next = S_TEST;
        end
      end
      S_TEST: begin
        op_next   = esc_pkg::OP_XY;
        step_next = '0;
        state_next = status.stop ? S_DONE : S_MUL;
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        if (step == esc_pkg::STEP_WB) begin
          step_next = '0;
          unique case (op)
            esc_pkg::OP_XY: op_next = esc_pkg::OP_XX;
            esc_pkg::OP_XX: op_next = esc_pkg::OP_YY;
            default:        state_next = S_TEST;
          endcase
        end else begin
          step_next = step + 3'd1;
        end
      end
      S_DONE: begin
        if (out_free) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      op       <= esc_pkg::OP_XY;
      step     <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      op    <= op_next;
      step  <= step_next;
      if (cmd.out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

### rtl/escape_time_fixed_point.sv
// Top level of the fixed-point escape-time iterator.
// The result becomes valid once the point has done its rounds and a final
// escape test; the next input can be taken in the cycle the result turns valid.
// Each round takes one escape test plus three products, each built in steps on
// one shared 32x32 multiplier; that multiplier sets the rate.
// One point is worked on at a time; a new point is taken while a result waits.
// Synchronous active-high reset; the iteration limit register resets to 256.
`timescale 1ns / 1ps
`default_nettype none
module escape_time_fixed_point #(
  parameter int FRAC_BITS = esc_pkg::FRAC_BITS_DEF,
  parameter int WORD_BITS = esc_pkg::WORD_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [esc_pkg::CNT_BITS-1:0]   cfg_data,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // Fields from bit 0: c_real[53:0], c_imag[107:54], zero padding.
  input  wire logic [esc_pkg::IN_TDATA-1:0]   s_tdata,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // Fields from bit 0: escape_count[15:0].
  output logic [esc_pkg::CNT_BITS-1:0]        m_tdata
);

  localparam int IB = esc_pkg::IN_BITS;

  esc_pkg::cmd_t    cmd;
  esc_pkg::status_t status;

  esc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .status   (status),
    .cmd      (cmd)
  );

  esc_datapath #(
    .FRAC_BITS (FRAC_BITS),
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_data     (cfg_data),
    .c_real       (s_tdata[IB-1:0]),
    .c_imag       (s_tdata[2*IB-1:IB]),
    .cmd          (cmd),
    .status       (status),
    .escape_count (m_tdata)
  );

endmodule
`default_nettype wire

### rtl/esc_checker.sv
// Port-level checker for the escape-time iterator, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module esc_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        s_tvalid,
  input wire logic        s_tready,
  input wire logic        m_tvalid,
  input wire logic        m_tready,
  input wire logic [15:0] m_tdata
);

  // After reset the block is empty and ready for a point.
  a_reset: assert property (@(posedge clk) rst |=> s_tready && !m_tvalid)
    else $error("block not idle after reset");

  // A point needs at least a load and an escape test before the next transfer.
  a_busy: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready ##1 !s_tready)
    else $error("input taken again too early");

  // A new result only appears while the block is busy with a point.
  a_result_src: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result appeared while idle");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

bind escape_time_fixed_point esc_checker u_esc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire

### sim/escape_time_checker.sv
// Checker for the escape-time iterator: predicts every escape count and compares it.
`timescale 1ns / 1ps
`default_nettype none
module escape_time_checker (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [esc_pkg::CNT_BITS-1:0] cfg_data,
  input  wire logic                         s_tvalid,
  input  wire logic                         s_tready,
  input  wire logic [esc_pkg::IN_TDATA-1:0] s_tdata,
  input  wire logic                         m_tvalid,
  input  wire logic                         m_tready,
  input  wire logic [esc_pkg::CNT_BITS-1:0] m_tdata,
  input  wire logic                         end_of_run,
  output int                                errors,
  output logic                              busy
);

  localparam int FRAC = esc_pkg::FRAC_BITS_DEF;
  localparam int IB   = esc_pkg::IN_BITS;
  localparam int CB   = esc_pkg::CNT_BITS;

  logic [CB-1:0] iter_limit = esc_pkg::MAX_ITER_RESET;
  logic [CB-1:0] pending_counts[$];
  logic          closed = 1'b0;

  // Exact signed product of two words, shifted right by FRAC and cut to a word.
  function automatic logic [63:0] fixed_mul(input logic [63:0] a, input logic [63:0] b);
    logic [127:0] prod;
    prod = {{64{a[63]}}, a} * {{64{b[63]}}, b};
    return prod[FRAC+63:FRAC];
  endfunction

  function automatic logic [CB-1:0] escape_rounds(input logic [IB-1:0] cr,
                                                  input logic [IB-1:0] ci,
                                                  input logic [CB-1:0] lim_reg);
    logic [63:0] cx, cy, zx, zy, x2, y2, four;
    logic [CB-1:0] cap;
    logic [CB:0] n;
    cx = {{(64-IB){cr[IB-1]}}, cr};
    cy = {{(64-IB){ci[IB-1]}}, ci};
    four = 64'd4 << FRAC;
    // A zero register wraps to the widest limit.
    cap = lim_reg - 1'b1;
    zx = '0;
    zy = '0;
    x2 = '0;
    y2 = '0;
    n = '0;
    while ($signed(x2 + y2) <= $signed(four) && n < cap) begin
      zy = (fixed_mul(zx, zy) << 1) + cy;
      zx = x2 - y2 + cx;
      x2 = fixed_mul(zx, zx);
      y2 = fixed_mul(zy, zy);
      n = n + 1'b1;
    end
    return n[CB-1:0];
  endfunction

  task automatic note_error(input string what, input int want, input int got);
    if (errors < 10) begin
      $display("%0t: %s: expected %0d, got %0d", $realtime, what, want, got);
    end
    errors++;
  endtask

  always @(posedge clk) begin
    logic [CB-1:0] want;
    if (rst) begin
      iter_limit = esc_pkg::MAX_ITER_RESET;
      pending_counts.delete();
    end else begin
      if (cfg_we) begin
        iter_limit = cfg_data;
      end
      if (s_tvalid && s_tready) begin
        pending_counts.push_back(escape_rounds(s_tdata[IB-1:0],
                                               s_tdata[2*IB-1:IB], iter_limit));
      end
      if (m_tvalid && m_tready) begin
        if (pending_counts.size() == 0) begin
          note_error("result transfer with no point outstanding", -1, m_tdata);
        end else begin
          want = pending_counts.pop_front();
          if (m_tdata !== want) begin
            note_error("escape_count mismatch", want, m_tdata);
          end
        end
      end
      if (end_of_run && !closed) begin
        closed = 1'b1;
        if (pending_counts.size() != 0) begin
          note_error("points still without a result", 0, pending_counts.size());
          errors += pending_counts.size() - 1;
        end
      end
    end
    busy <= (pending_counts.size() != 0);
  end

endmodule
`default_nettype wire

### sim/escape_time_fixed_point_test.sv
// Top of the escape-time iterator testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
`default_nettype none
module escape_time_fixed_point_test;

  localparam int IB = esc_pkg::IN_BITS;
  localparam int CB = esc_pkg::CNT_BITS;
  localparam int TB = esc_pkg::IN_TDATA;
  localparam logic signed [63:0] ONE = 64'sd1 << esc_pkg::FRAC_BITS_DEF;
  localparam logic [IB-1:0] MAXV = {1'b0, {(IB-1){1'b1}}};
  localparam logic [IB-1:0] MINV = {1'b1, {(IB-1){1'b0}}};

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          cfg_we = 1'b0;
  logic [CB-1:0] cfg_data = '0;
  logic          s_tvalid = 1'b0;
  logic          s_tready;
  logic [TB-1:0] s_tdata = '0;
  logic          m_tvalid;
  logic          m_tready = 1'b0;
  logic [CB-1:0] m_tdata;
  logic          gaps_on = 1'b0;
  logic          end_of_run = 1'b0;
  int            stall_left = 0;
  int            error_total;
  logic          busy;

  escape_time_fixed_point dut (
    .clk     (clk),
    .rst     (rst),
    .cfg_we  (cfg_we),
    .cfg_data(cfg_data),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata (s_tdata),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata (m_tdata)
  );

  escape_time_checker checker_i (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .end_of_run(end_of_run),
    .errors    (error_total),
    .busy      (busy)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: random stall bursts while idling is on.
  always @(posedge clk) begin
    if (!gaps_on) begin
      m_tready <= 1'b1;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 3) == 0) begin
      m_tready <= 1'b0;
      stall_left <= $urandom_range(0, 5);
    end else begin
      m_tready <= 1'b1;
    end
  end

  function automatic logic [IB-1:0] spread(input logic signed [63:0] lo,
                                           input logic [63:0] span);
    logic [63:0] r;
    r = {$urandom(), $urandom()};
    return IB'(lo + (r % span));
  endfunction

  task automatic push_point(input logic [IB-1:0] cr, input logic [IB-1:0] ci);
    int gap;
    if (gaps_on && $urandom_range(0, 2) == 0) begin
      gap = $urandom_range(1, 6);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {{(TB-2*IB){1'b0}}, ci, cr};
    do @(posedge clk); while (!s_tready);
  endtask

  // The register is only written once every outstanding point has its result.
  task automatic set_limit(input logic [CB-1:0] value);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (busy) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    int sel;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    gaps_on <= 1'b1;

    // Reset limit of 256: points inside the set, on the escape boundary, extremes.
    push_point('0, '0);
    push_point(IB'(-2 * ONE), '0);
    push_point(IB'(2 * ONE), '0);
    push_point('0, IB'(ONE));
    push_point(IB'(1), IB'(-1));
    push_point(MAXV, MAXV);
    push_point(MINV, MINV);
    push_point(MAXV, MINV);
    push_point(MINV, '0);
    push_point('0, MAXV);
    push_point(IB'(-(ONE * 3 / 4)), IB'(ONE / 128));
    push_point(IB'(ONE / 4 + ONE / 64), '0);

    // A limit of one means no round at all.
    set_limit(16'd1);
    push_point('0, '0);
    push_point(MAXV, MINV);

    set_limit(16'd2);
    push_point('0, '0);
    push_point(MINV, MAXV);

    // A zero register wraps to a limit of 65535; slow escapes show it.
    set_limit(16'd0);
    push_point(IB'(ONE / 4 + ONE / 8192), '0);
    push_point(IB'(-(ONE * 3 / 4)), IB'(ONE / 128));
    push_point(MAXV, '0);

    set_limit(16'hFFFF);
    push_point(IB'(ONE / 4 + ONE / 8192), '0);
    push_point(MINV, MINV);

    // Random phases: mostly points near the set, some full-range noise.
    for (int phase = 0; phase < 8; phase++) begin
      gaps_on <= (phase < 7) && ($urandom_range(0, 3) != 0);
      set_limit(CB'($urandom_range(2, 64)));
      repeat (200) begin
        sel = $urandom_range(0, 9);
        if (sel < 8) begin
          push_point(spread(-(ONE * 9 / 4), 3 * ONE), spread(-(ONE * 5 / 4), ONE * 5 / 2));
        end else begin
          push_point(IB'({$urandom(), $urandom()}), IB'({$urandom(), $urandom()}));
        end
      end
    end

    s_tvalid <= 1'b0;
    gaps_on <= 1'b0;
    @(posedge clk);
    while (busy) @(posedge clk);
    repeat (30) @(posedge clk);
    end_of_run <= 1'b1;
    repeat (2) @(posedge clk);
    if (error_total == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
`default_nettype wire
